/* design/softlock_and_cycle_detector_defines.svh */
// Assertion helpers used by the checker file scd_checker.
`ifndef SOFTLOCK_AND_CYCLE_DETECTOR_DEFINES_SVH
`define SOFTLOCK_AND_CYCLE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("softlock detector check failed");

// Next-cycle implication, disabled while reset is low.
`define SCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("softlock detector check failed");

`endif

/* design/scd_pkg.sv */
`default_nettype none
package scd_pkg;

  // History store geometry
  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);
  localparam int SCNT_W        = $clog2(HISTORY_DEPTH + 2);
  localparam int CMEM_W        = 5;
  localparam int CLAMP_W       = (HIST_CW > CMEM_W) ? HIST_CW : CMEM_W;
  localparam int MEM_MIN       = 2;

  // Field widths
  localparam int HASH_W     = 64;
  localparam int CNT_W      = 32;
  localparam int OUT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Outcome codes
  localparam logic [OUT_W-1:0] OUT_RUNNING  = 3'd0;
  localparam logic [OUT_W-1:0] OUT_OK       = 3'd1;
  localparam logic [OUT_W-1:0] OUT_SOFTLOCK = 3'd2;
  localparam logic [OUT_W-1:0] OUT_REPEAT   = 3'd3;
  localparam logic [OUT_W-1:0] OUT_IGNORED  = 3'd4;
  localparam logic [OUT_W-1:0] OUT_DRIVER   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STALL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_CYCLES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MEMORY  = 2'd3;

  // Configuration reset values
  localparam logic [CNT_W-1:0]  RST_MAX_STEPS    = 32'd1000;
  localparam logic [CNT_W-1:0]  RST_MAX_STALL    = 32'd16;
  localparam logic              RST_DETECT       = 1'b1;
  localparam logic [CMEM_W-1:0] RST_CYCLE_MEMORY = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic eval;
    logic search;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_search;
    logic search_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* design/scd_ram.sv */
`default_nettype none
module scd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/scd_ctrl.sv */
`default_nettype none
module scd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire scd_pkg::dp_status_t status,
  output scd_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands from the current state
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.eval    = (state_r == S_EVAL);
    cmd.search  = (state_r == S_SEARCH);
    cmd.commit  = (state_r == S_FINISH) && status.out_free;
  end

  // Advance through capture, evaluate, search and commit
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = status.need_search ? S_SEARCH : S_FINISH;
      end
      S_SEARCH: begin
        if (status.search_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/scd_datapath.sv */
`default_nettype none
module scd_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire scd_pkg::ctrl_cmd_t                    cmd,
  output scd_pkg::dp_status_t                        status,
  input  wire logic                                  in_new_trial,
  input  wire logic [scd_pkg::HASH_W-1:0]            in_state_hash,
  input  wire logic                                  in_progressed,
  input  wire logic                                  in_driver_failed,
  input  wire logic                                  cfg_we,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [scd_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                       ram_we,
  output logic      [scd_pkg::HIST_AW-1:0]           ram_waddr,
  output logic      [scd_pkg::HASH_W-1:0]            ram_wdata,
  output logic                                       ram_re,
  output logic      [scd_pkg::HIST_AW-1:0]           ram_raddr,
  input  wire logic [scd_pkg::HASH_W-1:0]            ram_rdata,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic      [scd_pkg::OUT_W-1:0]             out_outcome,
  output logic      [scd_pkg::CNT_W-1:0]             out_step_index,
  output logic      [scd_pkg::CNT_W-1:0]             out_stall_run
);

  // Configuration registers
  logic [scd_pkg::CNT_W-1:0]  max_steps_r, max_stall_r;
  logic                       detect_r;
  logic [scd_pkg::CMEM_W-1:0] cyc_mem_r;

  // Captured item
  logic                       new_trial_r, prog_r, drv_r;
  logic [scd_pkg::HASH_W-1:0] hash_r;

  // Trial state
  logic [scd_pkg::HIST_AW-1:0] head_r, head_nxt;
  logic [scd_pkg::HIST_CW-1:0] fill_r, fill_nxt;
  logic [scd_pkg::CNT_W-1:0]   stall_r, step_r;
  logic                        ended_r;

  // Search sweep
  logic [scd_pkg::SCNT_W-1:0]  cnt_r;
  logic                        cmp_vld_r, hit_r;

  // Result register
  logic                        out_valid_r;
  logic [scd_pkg::OUT_W-1:0]   out_outcome_r;
  logic [scd_pkg::CNT_W-1:0]   out_step_r, out_stall_r;

  logic [scd_pkg::CLAMP_W-1:0] cm_ext, cm_clamped;
  logic [scd_pkg::HIST_CW-1:0] mem_len, n_search;
  logic [scd_pkg::SCNT_W-1:0]  back_off;
  logic                        issue, match, sweep_done;

  logic [scd_pkg::CNT_W-1:0]   stall_inc, stall_new, step_inc, res_step, res_stall;
  logic [scd_pkg::CNT_W:0]     step_p1;
  logic [scd_pkg::OUT_W-1:0]   res_outcome;
  logic                        do_push, end_now;

  // Clamp the history length between MEM_MIN and the store depth
  always_comb begin
    cm_ext = scd_pkg::CLAMP_W'(cyc_mem_r);
    if (cm_ext < scd_pkg::CLAMP_W'(scd_pkg::MEM_MIN)) begin
      cm_clamped = scd_pkg::CLAMP_W'(scd_pkg::MEM_MIN);
    end else if (cm_ext > scd_pkg::CLAMP_W'(scd_pkg::HISTORY_DEPTH)) begin
      cm_clamped = scd_pkg::CLAMP_W'(scd_pkg::HISTORY_DEPTH);
    end else begin
      cm_clamped = cm_ext;
    end
    mem_len  = cm_clamped[scd_pkg::HIST_CW-1:0];
    n_search = (fill_r < mem_len) ? fill_r : mem_len;
  end

  // Walk back from the newest entry, one read a cycle
  always_comb begin
    back_off  = scd_pkg::SCNT_W'(scd_pkg::HISTORY_DEPTH) - cnt_r;
    if (cnt_r > scd_pkg::SCNT_W'(head_r)) begin
      ram_raddr = scd_pkg::HIST_AW'(back_off + scd_pkg::SCNT_W'(head_r));
    end else begin
      ram_raddr = scd_pkg::HIST_AW'(scd_pkg::SCNT_W'(head_r) - cnt_r);
    end
    sweep_done = (cnt_r > scd_pkg::SCNT_W'(n_search));
    issue  = cmd.search && !sweep_done;
    ram_re = issue;
    match  = cmp_vld_r && (ram_rdata == hash_r);
  end

  // Work out the step's result from the trial state
  always_comb begin
    stall_inc = (stall_r == '1) ? stall_r : stall_r + scd_pkg::CNT_W'(1);
    step_inc  = (step_r == '1) ? step_r : step_r + scd_pkg::CNT_W'(1);
    step_p1   = {1'b0, step_r} + (scd_pkg::CNT_W+1)'(1);
    stall_new = prog_r ? '0 : stall_inc;
    do_push   = 1'b0;
    res_step  = step_r;
    res_stall = stall_r;
    end_now   = 1'b0;
    res_outcome = scd_pkg::OUT_RUNNING;
    if (ended_r) begin
      res_outcome = scd_pkg::OUT_IGNORED;
    end else if (drv_r) begin
      res_outcome = scd_pkg::OUT_DRIVER;
      end_now     = 1'b1;
    end else begin
      res_stall = stall_new;
      if (!prog_r) begin
        if (stall_new >= max_stall_r) res_outcome = scd_pkg::OUT_SOFTLOCK;
      end else if (detect_r) begin
        if (hit_r) res_outcome = scd_pkg::OUT_REPEAT;
        else       do_push     = 1'b1;
      end
      if ((res_outcome == scd_pkg::OUT_RUNNING) && (step_p1 >= {1'b0, max_steps_r})) begin
        res_outcome = scd_pkg::OUT_OK;
      end
      end_now = (res_outcome != scd_pkg::OUT_RUNNING);
    end
    head_nxt = (head_r == scd_pkg::HIST_AW'(scd_pkg::HISTORY_DEPTH - 1)) ? '0
             : head_r + scd_pkg::HIST_AW'(1);
    fill_nxt = (fill_r < mem_len) ? fill_r + scd_pkg::HIST_CW'(1) : mem_len;
  end

  // Append the hash on a committed push
  always_comb begin
    ram_we    = cmd.commit && do_push;
    ram_waddr = head_r;
    ram_wdata = hash_r;
  end

  always_comb begin
    status.need_search = !(ended_r && !new_trial_r) && !drv_r && prog_r && detect_r;
    status.search_done = sweep_done;
    status.out_free    = !out_valid_r || out_ready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= scd_pkg::RST_MAX_STEPS;
      max_stall_r <= scd_pkg::RST_MAX_STALL;
      detect_r    <= scd_pkg::RST_DETECT;
      cyc_mem_r   <= scd_pkg::RST_CYCLE_MEMORY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scd_pkg::CFG_MAX_STEPS:     max_steps_r <= cfg_data;
        scd_pkg::CFG_MAX_STALL:     max_stall_r <= cfg_data;
        scd_pkg::CFG_DETECT_CYCLES: detect_r    <= cfg_data[0];
        scd_pkg::CFG_CYCLE_MEMORY:  cyc_mem_r   <= cfg_data[scd_pkg::CMEM_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_trial_r <= in_new_trial;
      hash_r      <= in_state_hash;
      prog_r      <= in_progressed;
      drv_r       <= in_driver_failed;
    end
  end

  // Trial state: clear on a new trial, update on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      stall_r <= '0;
      step_r  <= '0;
      ended_r <= 1'b0;
    end else if (cmd.eval && new_trial_r) begin
      head_r  <= '0;
      fill_r  <= '0;
      stall_r <= '0;
      step_r  <= '0;
      ended_r <= 1'b0;
    end else if (cmd.commit && !ended_r) begin
      if (end_now) ended_r <= 1'b1;
      if (!drv_r) begin
        stall_r <= stall_new;
        step_r  <= step_inc;
      end
      if (do_push) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  // Search sweep: address counter, compare stage and hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= scd_pkg::SCNT_W'(1);
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (cmd.eval) begin
        cnt_r <= scd_pkg::SCNT_W'(1);
        hit_r <= 1'b0;
      end else begin
        if (issue) cnt_r <= cnt_r + scd_pkg::SCNT_W'(1);
        if (match) hit_r <= 1'b1;
      end
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome_r <= res_outcome;
      out_step_r    <= res_step;
      out_stall_r   <= res_stall;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_step_index = out_step_r;
  assign out_stall_run  = out_stall_r;

endmodule
`default_nettype wire

/* design/softlock_and_cycle_detector.sv */
// Flow: an item is captured, evaluated, searched if needed, then committed to the
//   result register once it is free; in_ready stays low until that commit.
// Search: n = min(history fill, clamped cycle_memory) hashes, newest first; the
//   single comparator reads one stored hash a cycle from the history RAM port.
// Reset: synchronous, active low; registers return to defaults and the history
//   is empty by its fill count, with no clearing pass.
`default_nettype none
module softlock_and_cycle_detector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_new_trial,
  input  wire logic [scd_pkg::HASH_W-1:0]     in_state_hash,
  input  wire logic                           in_progressed,
  input  wire logic                           in_driver_failed,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [scd_pkg::OUT_W-1:0]      out_outcome,
  output logic      [scd_pkg::CNT_W-1:0]      out_step_index,
  output logic      [scd_pkg::CNT_W-1:0]      out_stall_run,
  input  wire logic                           cfg_we,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scd_pkg::CFG_DATA_W-1:0] cfg_data
);

  scd_pkg::ctrl_cmd_t  cmd;
  scd_pkg::dp_status_t status;

  logic                         ram_we, ram_re;
  logic [scd_pkg::HIST_AW-1:0]  ram_waddr, ram_raddr;
  logic [scd_pkg::HASH_W-1:0]   ram_wdata, ram_rdata;

  // Sequencer
  scd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Counters, compare and result register
  scd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_new_trial     (in_new_trial),
    .in_state_hash    (in_state_hash),
    .in_progressed    (in_progressed),
    .in_driver_failed (in_driver_failed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_outcome      (out_outcome),
    .out_step_index   (out_step_index),
    .out_stall_run    (out_stall_run)
  );

  // Hash history
  scd_ram #(
    .WIDTH (scd_pkg::HASH_W),
    .DEPTH (scd_pkg::HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

/* design/scd_checker.sv */
`default_nettype none
`include "softlock_and_cycle_detector_defines.svh"
module scd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [scd_pkg::OUT_W-1:0]      out_outcome,
  input wire logic [scd_pkg::CNT_W-1:0]      out_step_index,
  input wire logic [scd_pkg::CNT_W-1:0]      out_stall_run
);

  logic [scd_pkg::OUT_W+2*scd_pkg::CNT_W-1:0] out_payload;

  assign out_payload = {out_outcome, out_step_index, out_stall_run};

  // Only defined outcome codes reach the port
  `SCD_ASSERT_IMP(a_outcome_code, clk, rst_n, out_valid, out_outcome <= scd_pkg::OUT_DRIVER)

  // One item at a time: busy right after an accept
  `SCD_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A stalled result stays offered
  `SCD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload
  `SCD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

endmodule

bind softlock_and_cycle_detector scd_checker u_scd_checker (.*);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 95;

  typedef struct packed {
    logic                       new_trial;
    logic [scd_pkg::HASH_W-1:0] state_hash;
    logic                       progressed;
    logic                       driver_failed;
  } step_item_t;

  typedef struct packed {
    logic [scd_pkg::OUT_W-1:0] outcome;
    logic [scd_pkg::CNT_W-1:0] step_index;
    logic [scd_pkg::CNT_W-1:0] stall_run;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_new_trial = 1'b0;
  logic [scd_pkg::HASH_W-1:0] in_state_hash = '0;
  logic                       in_progressed = 1'b0;
  logic                       in_driver_failed = 1'b0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [scd_pkg::OUT_W-1:0] out_outcome;
  logic [scd_pkg::CNT_W-1:0] out_step_index;
  logic [scd_pkg::CNT_W-1:0] out_stall_run;

  logic                           cfg_we = 1'b0;
  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  softlock_and_cycle_detector u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_new_trial     (in_new_trial),
    .in_state_hash    (in_state_hash),
    .in_progressed    (in_progressed),
    .in_driver_failed (in_driver_failed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_step_index   (out_step_index),
    .out_stall_run    (out_stall_run),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queues between stimulus, driver and monitor
  step_item_t pending_steps[$];
  verdict_t   expected_verdicts[$];

  // Shadow of the configuration registers
  logic [scd_pkg::CNT_W-1:0]  lim_steps = scd_pkg::RST_MAX_STEPS;
  logic [scd_pkg::CNT_W-1:0]  lim_stall = scd_pkg::RST_MAX_STALL;
  logic                       cyc_on    = scd_pkg::RST_DETECT;
  logic [scd_pkg::CMEM_W-1:0] cyc_mem   = scd_pkg::RST_CYCLE_MEMORY;

  // Shadow of the trial state
  logic [scd_pkg::HASH_W-1:0] hist_mem [scd_pkg::HISTORY_DEPTH];
  int unsigned                hist_head = 0;
  int unsigned                hist_fill = 0;
  logic [scd_pkg::CNT_W-1:0]  stall_cnt = '0;
  logic [scd_pkg::CNT_W-1:0]  step_cnt = '0;
  logic                       trial_done = 1'b0;

  int unsigned steps_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned phases_run = 0;
  int unsigned outcome_hits [6];

  task automatic clear_trial();
    for (int i = 0; i < scd_pkg::HISTORY_DEPTH; i++) hist_mem[i] = '0;
    hist_head = 0;
    hist_fill = 0;
    stall_cnt = '0;
    step_cnt = '0;
    trial_done = 1'b0;
  endtask

  // Work out the verdict of one accepted step and queue it
  task automatic predict_verdict(input step_item_t it);
    verdict_t    v;
    logic [scd_pkg::CNT_W-1:0] step_no;
    int unsigned mem;
    int unsigned n;
    logic        hit;
    if (it.new_trial) clear_trial();
    step_no = step_cnt;
    v.outcome = scd_pkg::OUT_RUNNING;
    v.step_index = step_no;
    if (trial_done) begin
      v.outcome = scd_pkg::OUT_IGNORED;
      v.stall_run = stall_cnt;
    end else if (it.driver_failed) begin
      trial_done = 1'b1;
      v.outcome = scd_pkg::OUT_DRIVER;
      v.stall_run = stall_cnt;
    end else begin
      if (!it.progressed) begin
        if (stall_cnt != '1) stall_cnt = stall_cnt + 1'b1;
        if (stall_cnt >= lim_stall) v.outcome = scd_pkg::OUT_SOFTLOCK;
      end else begin
        stall_cnt = '0;
        if (cyc_on) begin
          mem = cyc_mem;
          if (mem < scd_pkg::MEM_MIN) mem = scd_pkg::MEM_MIN;
          if (mem > scd_pkg::HISTORY_DEPTH) mem = scd_pkg::HISTORY_DEPTH;
          n = (hist_fill < mem) ? hist_fill : mem;
          hit = 1'b0;
          for (int unsigned i = 1; i <= n; i++) begin
            if (hist_mem[(hist_head + scd_pkg::HISTORY_DEPTH - i) % scd_pkg::HISTORY_DEPTH]
                == it.state_hash)
              hit = 1'b1;
          end
          if (hit) begin
            v.outcome = scd_pkg::OUT_REPEAT;
          end else begin
            hist_mem[hist_head] = it.state_hash;
            hist_head = (hist_head + 1) % scd_pkg::HISTORY_DEPTH;
            if (hist_fill < mem) hist_fill++;
            else hist_fill = mem;
          end
        end
      end
      if (v.outcome == scd_pkg::OUT_RUNNING &&
          ({1'b0, step_no} + 33'd1 >= {1'b0, lim_steps}))
        v.outcome = scd_pkg::OUT_OK;
      if (step_cnt != '1) step_cnt = step_cnt + 1'b1;
      if (v.outcome != scd_pkg::OUT_RUNNING) trial_done = 1'b1;
      v.stall_run = stall_cnt;
    end
    expected_verdicts.insert(expected_verdicts.size(), v);
  endtask

  // Driver: offer queued items, random gap before each next item
  int unsigned in_wait = 0;
  logic        in_quiet = 1'b0;
  step_item_t  in_cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_verdict(in_cur);
        steps_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          in_cur = pending_steps[0];
          pending_steps.delete(0);
          in_new_trial <= in_cur.new_trial;
          in_state_hash <= in_cur.state_hash;
          in_progressed <= in_cur.progressed;
          in_driver_failed <= in_cur.driver_failed;
          in_valid <= 1'b1;
          if ($urandom_range(0, 29) == 0) in_quiet = !in_quiet;
          in_wait = in_quiet ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expected verdict
  int unsigned out_wait = 0;
  int unsigned out_hold = 0;
  logic        out_quiet = 1'b0;

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = 0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_outcome < 6) outcome_hits[out_outcome]++;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: outcome %0d step %0d stall %0d",
                     out_outcome, out_step_index, out_stall_run);
        end else begin
          want = expected_verdicts[0];
          expected_verdicts.delete(0);
          if (out_outcome !== want.outcome || out_step_index !== want.step_index ||
              out_stall_run !== want.stall_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected outcome %0d step %0d stall %0d, got %0d %0d %0d",
                       results_seen, want.outcome, want.step_index, want.stall_run,
                       out_outcome, out_step_index, out_stall_run);
          end
        end
        // Back up the block now and then
        if (results_seen == 150 || results_seen == 600) out_hold = LONG_HOLD;
        if ($urandom_range(0, 29) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 8);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any handshake or register write
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("softlock_and_cycle_detector: mismatch");
        $finish;
      end
    end
  end

  function automatic step_item_t mk_step(input logic nt, input logic [scd_pkg::HASH_W-1:0] h,
                                         input logic prog, input logic df);
    step_item_t s;
    s.new_trial = nt;
    s.state_hash = h;
    s.progressed = prog;
    s.driver_failed = df;
    return s;
  endfunction

  // Append one item to the driver's queue
  task automatic add_step(input step_item_t s);
    pending_steps.insert(pending_steps.size(), s);
  endtask

  task automatic write_reg(input logic [scd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scd_pkg::CFG_MAX_STEPS:     lim_steps = val;
      scd_pkg::CFG_MAX_STALL:     lim_stall = val;
      scd_pkg::CFG_DETECT_CYCLES: cyc_on = val[0];
      scd_pkg::CFG_CYCLE_MEMORY:  cyc_mem = val[scd_pkg::CMEM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] ms, input logic [31:0] mst,
                            input logic det, input logic [31:0] cm);
    write_reg(scd_pkg::CFG_MAX_STEPS, ms);
    write_reg(scd_pkg::CFG_MAX_STALL, mst);
    write_reg(scd_pkg::CFG_DETECT_CYCLES, {31'd0, det});
    write_reg(scd_pkg::CFG_CYCLE_MEMORY, cm);
  endtask

  // Hold until every queued item is in and every verdict is out; sample
  // between edges so the driver's updates have settled
  task automatic drain();
    while (pending_steps.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(negedge clk);
    phases_run++;
  endtask

  // Queue one trial: mostly progress, stall runs, revisited hashes, rare noise
  task automatic queue_trial(input int len, input logic fresh);
    logic [scd_pkg::HASH_W-1:0] recent[$];
    logic [scd_pkg::HASH_W-1:0] h;
    int   stall_left;
    int   back;
    logic nt;
    logic prog;
    stall_left = 0;
    for (int i = 0; i < len; i++) begin
      nt = (i == 0) ? fresh : ($urandom_range(0, 39) == 0);
      if (nt) recent.delete();
      if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      prog = (stall_left == 0);
      if (stall_left > 0) stall_left--;
      if (recent.size() > 0 && $urandom_range(0, 4) == 0) begin
        back = $urandom_range(0, (recent.size() < 20 ? recent.size() : 20) - 1);
        h = recent[recent.size() - 1 - back];
      end else begin
        case ($urandom_range(0, 19))
          0:       h = '0;
          1:       h = '1;
          default: h = {$urandom, $urandom};
        endcase
      end
      recent.insert(recent.size(), h);
      add_step(mk_step(nt, h, prog, $urandom_range(0, 49) == 0));
    end
  endtask

  initial begin
    logic [31:0] ms;
    logic [31:0] mst;
    logic        det;
    logic [31:0] cm;
    int queued;
    int len;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: extreme hashes, then a revisit ends as repeat
    add_step(mk_step(1'b1, '0, 1'b1, 1'b0));
    add_step(mk_step(1'b0, '1, 1'b1, 1'b0));
    add_step(mk_step(1'b0, '0, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'd5, 1'b0, 1'b1));
    drain();

    // Short budget, tight stall limit, memory below its clamp
    set_config(32'd3, 32'd2, 1'b1, 32'd0);
    add_step(mk_step(1'b1, 64'hA, 1'b0, 1'b0));
    add_step(mk_step(1'b0, 64'hA, 1'b0, 1'b0));
    add_step(mk_step(1'b1, 64'hB, 1'b1, 1'b1));
    add_step(mk_step(1'b0, 64'hB, 1'b1, 1'b0));
    add_step(mk_step(1'b1, 64'h1, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'h2, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'h3, 1'b1, 1'b0));
    add_step(mk_step(1'b1, 64'h1, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'h2, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'h1, 1'b1, 1'b0));
    drain();

    // Zero budget and zero stall limit
    set_config(32'd0, 32'd0, 1'b0, 32'd16);
    add_step(mk_step(1'b1, 64'h7, 1'b1, 1'b0));
    add_step(mk_step(1'b1, 64'h7, 1'b0, 1'b0));
    add_step(mk_step(1'b0, 64'h7, 1'b1, 1'b0));
    drain();

    // Maximum limits, detection off, memory above its clamp
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd31);
    add_step(mk_step(1'b1, 64'h7, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'h7, 1'b1, 1'b0));
    add_step(mk_step(1'b0, 64'h7, 1'b0, 1'b0));
    add_step(mk_step(1'b0, 64'h7, 1'b0, 1'b0));
    add_step(mk_step(1'b0, 64'h8, 1'b0, 1'b0));
    drain();

    // Random phases, each under its own settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1:       ms = 32'd1;
        2:       ms = 32'd0;
        4:       ms = 32'hFFFF_FFFF;
        default: ms = $urandom_range(4, 40);
      endcase
      case (p)
        1:       mst = 32'd1;
        3:       mst = 32'd0;
        4:       mst = 32'hFFFF_FFFF;
        default: mst = $urandom_range(2, 8);
      endcase
      det = (p == 5) ? 1'b0 : ($urandom_range(0, 5) != 0);
      case (p)
        0:       cm = 32'd0;
        6:       cm = 32'd31;
        7:       cm = 32'd16;
        8:       cm = 32'd2;
        default: cm = $urandom_range(0, 31);
      endcase
      set_config(ms, mst, det, cm);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if (ms == 0) len = $urandom_range(1, 3);
        else if (ms <= 40) len = ms + $urandom_range(0, 3);
        else len = $urandom_range(5, 50);
        // Keep each phase at its item count
        if (len > PHASE_ITEMS - queued) len = PHASE_ITEMS - queued;
        // Carry the previous trial over a settings change now and then
        queue_trial(len, (queued != 0) || ($urandom_range(0, 2) != 0));
        queued += len;
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("ran %0d items in %0d settings phases, %0d results checked",
             steps_sent, phases_run, results_seen);
    $display("outcomes running %0d ok %0d softlock %0d repeat %0d ignored %0d driver %0d",
             outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
             outcome_hits[4], outcome_hits[5]);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("softlock_and_cycle_detector: match");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", mismatches,
               expected_verdicts.size());
      $display("softlock_and_cycle_detector: mismatch");
    end
    $finish;
  end

endmodule
